>>> rtl/line_sensor_sweep_calibrator_unit_assert.svh
// ----------------------------------------------------------------------------
// Line sensor sweep calibrator assertion macros
// Concurrent checks on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef LINE_SENSOR_SWEEP_CALIBRATOR_UNIT_ASSERT_SVH
`define LINE_SENSOR_SWEEP_CALIBRATOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define LSC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lsc: same-cycle check failed");
// Consequent must hold in the cycle after the antecedent.
`define LSC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lsc: next-cycle check failed");
`else
`define LSC_ASSERT_NOW(lbl, ante, cons)
`define LSC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> rtl/lsc_pkg.sv
// ----------------------------------------------------------------------------
// Line sensor sweep calibrator package
// Shared widths, phase codes and the records passed between the modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lsc_pkg;

  localparam int SENSOR_COUNT = 8;
  localparam int SAMPLE_BITS  = 10;
  localparam int MARGIN_BITS  = 10;
  localparam int QUERY_BITS   = 3;
  localparam int PHASE_BITS   = 3;

  localparam logic [MARGIN_BITS-1:0] MARGIN_RESET = MARGIN_BITS'(100);

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [MARGIN_BITS-1:0] margin_t;
  typedef logic [QUERY_BITS-1:0]  query_t;

  typedef enum logic [PHASE_BITS-1:0] {
    PH_COLOUR       = 3'd0,
    PH_ZERO         = 3'd1,
    PH_NINETY       = 3'd2,
    PH_SECOND_ZERO  = 3'd3,
    PH_MINUS_NINETY = 3'd4,
    PH_DONE         = 3'd5
  } phase_t;

  // What one lane reports for the current frame: levels as they stand after it.
  typedef struct packed {
    logic    near;
    sample_t hi;
    sample_t lo;
  } lane_stat_t;

  // One result beat.
  typedef struct packed {
    phase_t  phase;
    logic    line_white;
    logic    turn_right;
    logic    near_line;
    sample_t white_level;
    sample_t black_level;
  } sweep_res_t;

endpackage

>>> rtl/lsc_lane.sv
// ----------------------------------------------------------------------------
// Line sensor sweep calibrator lane
// Tracks the maximum and minimum of one sensor and tests its reading
// against the line reference.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsc_lane import lsc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       update,
  input  sample_t    sample,
  input  sample_t    reference,
  input  margin_t    margin,
  output lane_stat_t stat
);

  sample_t hi;
  sample_t lo;
  sample_t hi_next;
  sample_t lo_next;
  sample_t diff;

  always_comb begin
    diff    = (sample > reference) ? sample - reference : reference - sample;
    hi_next = (update && (sample > hi)) ? sample : hi;
    lo_next = (update && (sample < lo)) ? sample : lo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hi <= '0;
      lo <= '1;
    end else begin
      hi <= hi_next;
      lo <= lo_next;
    end
  end

  assign stat.near = (diff < margin);
  assign stat.hi   = hi_next;
  assign stat.lo   = lo_next;

endmodule

>>> rtl/lsc_sweep.sv
// ----------------------------------------------------------------------------
// Line sensor sweep calibrator merge stage
// Classifies the line colour, runs the sweep phase machine on the lanes'
// combined near flag and picks the queried sensor's levels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsc_sweep import lsc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  sample_t    centre,
  input  sample_t    edge_left,
  input  sample_t    edge_right,
  input  query_t     query,
  input  lane_stat_t lanes [SENSOR_COUNT],
  output logic       sweeping,
  output sample_t    reference,
  output sweep_res_t res
);

  phase_t  state;
  phase_t  state_step;
  phase_t  state_next;
  logic    white;
  logic    white_next;
  sample_t reference_next;
  logic    any_near;
  logic    turn;
  logic    colour_frame;
  logic [SAMPLE_BITS:0] edge_sum;
  sample_t edge_mean;

  always_comb begin
    any_near = 1'b0;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      any_near = any_near | lanes[i].near;
    end
  end

  // Next phase for an accepted frame.
  always_comb begin
    unique case (state)
      PH_COLOUR:       state_step = PH_ZERO;
      PH_ZERO:         state_step = any_near ? PH_ZERO : PH_NINETY;
      PH_NINETY:       state_step = any_near ? PH_SECOND_ZERO : PH_NINETY;
      PH_SECOND_ZERO:  state_step = any_near ? PH_SECOND_ZERO : PH_MINUS_NINETY;
      PH_MINUS_NINETY: state_step = any_near ? PH_DONE : PH_MINUS_NINETY;
      default:         state_step = state;
    endcase
    state_next = accept ? state_step : state;
  end

  // Outputs decoded from the current phase.
  always_comb begin
    unique case (state)
      PH_COLOUR: begin
        colour_frame = 1'b1;
        sweeping     = 1'b0;
        turn         = 1'b0;
      end
      PH_ZERO, PH_MINUS_NINETY: begin
        colour_frame = 1'b0;
        sweeping     = 1'b1;
        turn         = 1'b0;
      end
      PH_NINETY, PH_SECOND_ZERO: begin
        colour_frame = 1'b0;
        sweeping     = 1'b1;
        turn         = 1'b1;
      end
      default: begin
        colour_frame = 1'b0;
        sweeping     = 1'b0;
        turn         = 1'b0;
      end
    endcase
  end

  // The line counts as white when the centre is brighter than the edge mean.
  always_comb begin
    edge_sum  = {1'b0, edge_left} + {1'b0, edge_right};
    edge_mean = edge_sum[SAMPLE_BITS:1];
    if (accept && colour_frame) begin
      white_next     = (centre > edge_mean);
      reference_next = centre;
    end else begin
      white_next     = white;
      reference_next = reference;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= PH_COLOUR;
      white     <= 1'b0;
      reference <= '0;
    end else begin
      state     <= state_next;
      white     <= white_next;
      reference <= reference_next;
    end
  end

  always_comb begin
    res.phase      = state_next;
    res.line_white = white_next;
    res.turn_right = turn;
    res.near_line  = sweeping & any_near;
    if (int'(query) < SENSOR_COUNT) begin
      res.white_level = lanes[query].hi;
      res.black_level = lanes[query].lo;
    end else begin
      res.white_level = '0;
      res.black_level = '0;
    end
  end

endmodule

>>> rtl/line_sensor_sweep_calibrator_unit.sv
// ----------------------------------------------------------------------------
// Line sensor sweep calibrator
// Colour detection, four-step sweep and per-sensor level tracking for an
// eight-sensor reflectance bar.
// ----------------------------------------------------------------------------
// The block takes one frame per clock cycle unless the output stalls, and returns
// one result beat per frame, in the cycle after the frame is accepted, from an
// output register. The rate is set by the phase register, which every frame
// updates from the OR of the eight lane compares. A frame is taken whenever the
// output register is empty or its beat is being taken in the same cycle. The
// margin register may be written only while no beat is outstanding; it resets to 100.
`timescale 1ns / 1ps

`include "line_sensor_sweep_calibrator_unit_assert.svh"

module line_sensor_sweep_calibrator_unit import lsc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    cfg_we,
  input  margin_t cfg_wdata,
  input  logic    in_valid,
  output logic    in_stall,
  input  sample_t sample_0,
  input  sample_t sample_1,
  input  sample_t sample_2,
  input  sample_t sample_3,
  input  sample_t sample_4,
  input  sample_t sample_5,
  input  sample_t sample_6,
  input  sample_t sample_7,
  input  query_t  query_sensor,
  output logic    out_valid,
  input  logic    out_stall,
  output phase_t  phase,
  output logic    line_white,
  output logic    turn_right,
  output logic    near_line,
  output sample_t white_level,
  output sample_t black_level
);

  margin_t    near_margin;
  sample_t    samples [SENSOR_COUNT];
  lane_stat_t lanes [SENSOR_COUNT];
  logic       accept;
  logic       sweeping;
  logic       lane_update;
  sample_t    reference;
  sweep_res_t res;
  sweep_res_t res_q;
  logic       out_valid_next;

  assign samples[0] = sample_0;
  assign samples[1] = sample_1;
  assign samples[2] = sample_2;
  assign samples[3] = sample_3;
  assign samples[4] = sample_4;
  assign samples[5] = sample_5;
  assign samples[6] = sample_6;
  assign samples[7] = sample_7;

  assign in_stall    = out_valid & out_stall;
  assign accept      = in_valid & ~in_stall;
  assign lane_update = accept & sweeping;

  always_ff @(posedge clk) begin
    if (rst) begin
      near_margin <= MARGIN_RESET;
    end else if (cfg_we) begin
      near_margin <= cfg_wdata;
    end
  end

  for (genvar g = 0; g < SENSOR_COUNT; g++) begin : g_lane
    lsc_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .update    (lane_update),
      .sample    (samples[g]),
      .reference (reference),
      .margin    (near_margin),
      .stat      (lanes[g])
    );
  end

  lsc_sweep u_sweep (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .centre     (samples[SENSOR_COUNT/2]),
    .edge_left  (samples[0]),
    .edge_right (samples[SENSOR_COUNT-1]),
    .query      (query_sensor),
    .lanes      (lanes),
    .sweeping   (sweeping),
    .reference  (reference),
    .res        (res)
  );

  assign out_valid_next = accept | (out_valid & out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign phase       = res_q.phase;
  assign line_white  = res_q.line_white;
  assign turn_right  = res_q.turn_right;
  assign near_line   = res_q.near_line;
  assign white_level = res_q.white_level;
  assign black_level = res_q.black_level;

  // Once the sweep is done, every later beat reports done.
  `LSC_ASSERT_NEXT(a_done_sticky, accept && out_valid && (phase == PH_DONE), out_valid && (phase == PH_DONE))
  // A frame that found the line also updated both levels of every sensor.
  `LSC_ASSERT_NOW(a_levels_ordered, out_valid && near_line, white_level >= black_level)
  // A right turn only happens in the two middle steps of the sweep.
  `LSC_ASSERT_NOW(a_turn_phase, out_valid && turn_right, (phase == PH_NINETY) || (phase == PH_SECOND_ZERO) || (phase == PH_MINUS_NINETY))

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// Line sensor sweep calibrator testbench
// Sends sensor frames through colour detection, the four-step sweep and the
// done phase. Each frame is predicted by a local tracker of the calibration
// state, and every result beat is compared field by field. The margin register
// is moved between phases, and both sides of the block idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import lsc_pkg::*;

  localparam int SAMPLE_MAX     = (1 << SAMPLE_BITS) - 1;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PHASE_BUDGET   = 250;
  localparam int HOLD_CYCLES    = 80;
  localparam int SEND_SIDE      = 0;
  localparam int RECV_SIDE      = 1;

  typedef struct packed {
    sample_t [SENSOR_COUNT-1:0] smp;
    query_t                     q;
  } frame_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    cfg_we = 1'b0;
  margin_t cfg_wdata = '0;
  logic    in_valid = 1'b0;
  logic    in_stall;
  sample_t sample_0 = '0;
  sample_t sample_1 = '0;
  sample_t sample_2 = '0;
  sample_t sample_3 = '0;
  sample_t sample_4 = '0;
  sample_t sample_5 = '0;
  sample_t sample_6 = '0;
  sample_t sample_7 = '0;
  query_t  query_sensor = '0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  phase_t  phase;
  logic    line_white;
  logic    turn_right;
  logic    near_line;
  sample_t white_level;
  sample_t black_level;

  // Calibration state as the block should hold it after every accepted frame.
  phase_t  sweep_now;
  logic    white_now;
  sample_t line_ref;
  margin_t margin_now;
  sample_t seen_max [SENSOR_COUNT];
  sample_t seen_min [SENSOR_COUNT];

  sweep_res_t predicted_reports [$];
  int mismatch_count = 0;
  int beat_count = 0;
  int quiet_cycles = 0;
  int hold_request = 0;
  int spread = 8;
  int zero_streak [2] = '{0, 0};

  line_sensor_sweep_calibrator_unit dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample_0     (sample_0),
    .sample_1     (sample_1),
    .sample_2     (sample_2),
    .sample_3     (sample_3),
    .sample_4     (sample_4),
    .sample_5     (sample_5),
    .sample_6     (sample_6),
    .sample_7     (sample_7),
    .query_sensor (query_sensor),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .phase        (phase),
    .line_white   (line_white),
    .turn_right   (turn_right),
    .near_line    (near_line),
    .white_level  (white_level),
    .black_level  (black_level)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void reset_tracker();
    sweep_now  = PH_COLOUR;
    white_now  = 1'b0;
    line_ref   = '0;
    margin_now = MARGIN_RESET;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      seen_max[i] = '0;
      seen_min[i] = sample_t'(SAMPLE_MAX);
    end
  endfunction

  function automatic sweep_res_t calibrate_frame(frame_t f);
    sweep_res_t r;
    logic hit;
    logic go_right;
    logic [SAMPLE_BITS:0] edge_sum;
    sample_t offset;
    hit = 1'b0;
    go_right = 1'b0;
    if (sweep_now == PH_COLOUR) begin
      edge_sum = f.smp[0] + f.smp[SENSOR_COUNT-1];
      white_now = f.smp[SENSOR_COUNT/2] > edge_sum[SAMPLE_BITS:1];
      line_ref = f.smp[SENSOR_COUNT/2];
      sweep_now = PH_ZERO;
    end else if (sweep_now != PH_DONE) begin
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        if (f.smp[i] > seen_max[i]) seen_max[i] = f.smp[i];
        if (f.smp[i] < seen_min[i]) seen_min[i] = f.smp[i];
        offset = (f.smp[i] > line_ref) ? f.smp[i] - line_ref : line_ref - f.smp[i];
        if (offset < margin_now) hit = 1'b1;
      end
      case (sweep_now)
        PH_ZERO: begin
          if (!hit) sweep_now = PH_NINETY;
        end
        PH_NINETY: begin
          go_right = 1'b1;
          if (hit) sweep_now = PH_SECOND_ZERO;
        end
        PH_SECOND_ZERO: begin
          go_right = 1'b1;
          if (!hit) sweep_now = PH_MINUS_NINETY;
        end
        default: begin
          if (hit) sweep_now = PH_DONE;
        end
      endcase
    end
    r.phase       = sweep_now;
    r.line_white  = white_now;
    r.turn_right  = go_right;
    r.near_line   = hit;
    r.white_level = seen_max[f.q];
    r.black_level = seen_min[f.q];
    return r;
  endfunction

  // Mostly random waits, with occasional runs of back-to-back beats.
  function automatic int draw_wait(int side);
    if (zero_streak[side] > 0) begin
      zero_streak[side]--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      zero_streak[side] = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  function automatic sample_t wide_sample();
    int pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return '0;
    if (pick == 1) return sample_t'(SAMPLE_MAX);
    return sample_t'($urandom_range(0, SAMPLE_MAX));
  endfunction

  // The window widens as the sweep goes on, so the stored levels keep moving.
  function automatic sample_t window_sample();
    int lo;
    int hi;
    lo = (spread >= 512) ? 0 : 512 - spread;
    hi = (spread >= 512) ? SAMPLE_MAX : 511 + spread;
    return sample_t'($urandom_range(lo, hi));
  endfunction

  function automatic sample_t near_sample(bit exact);
    int r;
    int d;
    r = line_ref;
    d = exact ? int'(margin_now) - 1 : $urandom_range(0, int'(margin_now) - 1);
    if (r + d <= SAMPLE_MAX && ($urandom_range(0, 1) == 1 || d > r)) return sample_t'(r + d);
    if (d <= r) return sample_t'(r - d);
    return line_ref;
  endfunction

  function automatic sample_t far_sample(bit exact);
    int r;
    int m;
    bit lo_ok;
    bit hi_ok;
    r = line_ref;
    m = margin_now;
    lo_ok = r >= m;
    hi_ok = r + m <= SAMPLE_MAX;
    if (lo_ok && (!hi_ok || $urandom_range(0, 1) == 1))
      return exact ? sample_t'(r - m) : sample_t'($urandom_range(0, r - m));
    if (hi_ok)
      return exact ? sample_t'(r + m) : sample_t'($urandom_range(r + m, SAMPLE_MAX));
    return '0;
  endfunction

  // A near frame has at least one sensor inside the margin; a far frame has none.
  function automatic frame_t make_frame(bit want_near);
    frame_t f;
    f.q = query_t'($urandom_range(0, SENSOR_COUNT - 1));
    for (int i = 0; i < SENSOR_COUNT; i++)
      f.smp[i] = want_near ? window_sample() : far_sample($urandom_range(0, 3) == 0);
    if (want_near)
      f.smp[$urandom_range(0, SENSOR_COUNT - 1)] = near_sample($urandom_range(0, 3) == 0);
    return f;
  endfunction

  function automatic frame_t noise_frame();
    frame_t f;
    f.q = query_t'($urandom_range(0, SENSOR_COUNT - 1));
    for (int i = 0; i < SENSOR_COUNT; i++) f.smp[i] = wide_sample();
    return f;
  endfunction

  // Any margin from here keeps both near and far frames possible.
  function automatic margin_t margin_pick();
    int top;
    int pick;
    top = (line_ref > SAMPLE_MAX - line_ref) ? int'(line_ref) : SAMPLE_MAX - int'(line_ref);
    pick = $urandom_range(0, 7);
    if (pick == 0) return margin_t'($urandom_range(1, 8));
    if (pick == 1) return margin_t'(top);
    return margin_t'($urandom_range(1, top));
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR: %s", msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want)
      report_mismatch($sformatf("beat %0d %s: got %0d, expected %0d",
                                beat_count, name, got, want));
  endtask

  // Called at a clock edge; leaves in_valid high after the beat so that a
  // following frame can go out without a gap.
  task automatic send_frame(frame_t f, bit no_gap);
    int gap;
    gap = no_gap ? 0 : draw_wait(SEND_SIDE);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    sample_0     <= f.smp[0];
    sample_1     <= f.smp[1];
    sample_2     <= f.smp[2];
    sample_3     <= f.smp[3];
    sample_4     <= f.smp[4];
    sample_5     <= f.smp[5];
    sample_6     <= f.smp[6];
    sample_7     <= f.smp[7];
    query_sensor <= f.q;
    do @(posedge clk); while (in_stall);
    predicted_reports.push_back(calibrate_frame(f));
    if (spread < SAMPLE_MAX) spread++;
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (predicted_reports.size() != 0);
  endtask

  task automatic write_margin(margin_t v);
    wait_all_results();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    margin_now = v;
  endtask

  task automatic run_sweep_phase(phase_t p, int budget, bit finish_it);
    int n;
    bit stay_near;
    stay_near = (p == PH_ZERO || p == PH_SECOND_ZERO);
    n = 0;
    while (sweep_now == p && n < budget) begin
      if (p != PH_MINUS_NINETY && $urandom_range(0, 99) < 6) send_frame(noise_frame(), 1'b0);
      else send_frame(make_frame(stay_near), 1'b0);
      n++;
    end
    while (finish_it && sweep_now == p) send_frame(make_frame(!stay_near), 1'b0);
  endtask

  // The edge mean must use the full carry: two full-scale edges give a black line; edges of 0 and 1 give a white one.
  task automatic test_colour_frame();
    frame_t f;
    f = noise_frame();
    if ($urandom_range(0, 1) == 1) begin
      f.smp[0] = sample_t'(SAMPLE_MAX);
      f.smp[SENSOR_COUNT-1] = sample_t'(SAMPLE_MAX);
      f.smp[SENSOR_COUNT/2] = sample_t'($urandom_range(0, SAMPLE_MAX));
    end else begin
      f.smp[0] = '0;
      f.smp[SENSOR_COUNT-1] = sample_t'(1);
      f.smp[SENSOR_COUNT/2] = sample_t'($urandom_range(1, SAMPLE_MAX));
    end
    send_frame(f, 1'b0);
  endtask

  // Reset margin; each lane in turn sits one step inside it while the rest are far.
  task automatic test_near_boundary();
    frame_t f;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      f.q = query_t'(i);
      for (int k = 0; k < SENSOR_COUNT; k++) f.smp[k] = far_sample(k[0]);
      f.smp[i] = near_sample(1'b1);
      send_frame(f, 1'b0);
    end
  endtask

  task automatic test_random_sweep();
    for (int p = PH_ZERO; p <= PH_MINUS_NINETY; p++) begin
      write_margin(margin_pick());
      run_sweep_phase(phase_t'(p), PHASE_BUDGET, p != PH_MINUS_NINETY);
    end
  endtask

  // The receiver holds off while frames keep coming, so the block must stall.
  task automatic test_long_hold();
    hold_request = HOLD_CYCLES;
    repeat (30) send_frame(make_frame(1'b0), 1'b1);
    wait_all_results();
  endtask

  task automatic test_margin_extremes();
    frame_t f;
    write_margin('0);
    f.q = query_t'($urandom_range(0, SENSOR_COUNT - 1));
    for (int i = 0; i < SENSOR_COUNT; i++) f.smp[i] = line_ref;
    send_frame(f, 1'b0);
    f.q = query_t'($urandom_range(0, SENSOR_COUNT - 1));
    f.smp = '0;
    send_frame(f, 1'b0);
    f.q = query_t'($urandom_range(0, SENSOR_COUNT - 1));
    f.smp = '1;
    send_frame(f, 1'b0);
    write_margin(margin_t'(SAMPLE_MAX));
    while (sweep_now != PH_DONE) send_frame(make_frame(1'b1), 1'b0);
  endtask

  // Once done, frames only report the stored levels.
  task automatic test_after_done();
    write_margin(margin_pick());
    repeat (100) send_frame(noise_frame(), 1'b0);
  endtask

  initial begin
    reset_tracker();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_colour_frame();
    test_near_boundary();
    test_random_sweep();
    test_long_hold();
    test_margin_extremes();
    test_after_done();
    wait_all_results();
    repeat (8) @(posedge clk);
    if (predicted_reports.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", predicted_reports.size()));
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : result_receiver
    int n;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_request > 0) begin
        n = hold_request;
        hold_request = 0;
      end else begin
        n = draw_wait(RECV_SIDE);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  always @(posedge clk) begin : beat_check
    sweep_res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (predicted_reports.size() == 0) begin
        report_mismatch($sformatf("beat %0d arrived with nothing expected", beat_count));
      end else begin
        want = predicted_reports.pop_front();
        check_field("phase", int'(phase), int'(want.phase));
        check_field("line_white", int'(line_white), int'(want.line_white));
        check_field("turn_right", int'(turn_right), int'(want.turn_right));
        check_field("near_line", int'(near_line), int'(want.near_line));
        check_field("white_level", int'(white_level), int'(want.white_level));
        check_field("black_level", int'(black_level), int'(want.black_level));
      end
      beat_count++;
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

endmodule
